/* rtl/core/gpbc_pkg.sv */
// Shared types and constants for the glyph pixel blend and clip unit.
package gpbc_pkg;

    localparam int COORD_BITS = 12;
    localparam int REG_BITS   = 13;
    localparam int ADDR_BITS  = 24;
    localparam int CHAN_BITS  = 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CHAN_BITS-1:0] ALPHA_FULL  = 8'hff;
    localparam logic [CHAN_BITS-1:0] ALPHA_ZERO  = 8'h00;
    localparam logic [15:0]          ROUND_BIAS  = 16'h0080;
    localparam logic [7:0]           OPAQUE      = 8'hff;

    localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STRIDE     = 2'd2;

    localparam logic [REG_BITS-1:0] RST_SURFACE_WIDTH  = 13'd640;
    localparam logic [REG_BITS-1:0] RST_SURFACE_HEIGHT = 13'd480;
    localparam logic [REG_BITS-1:0] RST_ROW_STRIDE     = 13'd640;

    typedef enum logic {
        KIND_FILL  = 1'b0,
        KIND_BLEND = 1'b1
    } pixel_kind_t;

    typedef enum logic [1:0] {
        MODE_BG  = 2'd0,
        MODE_FG  = 2'd1,
        MODE_MIX = 2'd2
    } mix_mode_t;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [7:0]            coverage;
        logic [23:0]           fg_color;
        logic [23:0]           bg_color;
    } item_t;

    typedef struct packed {
        logic                 write_enable;
        logic [ADDR_BITS-1:0] word_address;
        logic [31:0]          pixel_value;
    } result_t;

    typedef struct packed {
        logic [REG_BITS-1:0] surface_width;
        logic [REG_BITS-1:0] surface_height;
        logic [REG_BITS-1:0] row_stride;
    } surface_cfg_t;

endpackage

/* rtl/core/gpbc_mix.sv */
// Three-stage blend of one 8-bit color channel by coverage.
module gpbc_mix
    import gpbc_pkg::*;
(
    input  logic                 clk,
    input  mix_mode_t            mode,
    input  logic [CHAN_BITS-1:0] coverage,
    input  logic [CHAN_BITS-1:0] fg,
    input  logic [CHAN_BITS-1:0] bg,
    output logic [CHAN_BITS-1:0] chan
);

    // stage 1: products
    logic [15:0]          prod_f_reg, prod_b_reg;
    logic [CHAN_BITS-1:0] fg1_reg, bg1_reg;
    mix_mode_t            mode1_reg;
    // stage 2: rounded sum
    logic [15:0]          sum_reg;
    logic [CHAN_BITS-1:0] fg2_reg, bg2_reg;
    mix_mode_t            mode2_reg;
    // stage 3: result
    logic [CHAN_BITS-1:0] chan_reg;

    logic [15:0]          corr;
    logic [CHAN_BITS-1:0] chan_next;

    always_ff @(posedge clk)
    begin
        prod_f_reg <= 16'(fg) * 16'(coverage);
        prod_b_reg <= 16'(bg) * 16'(ALPHA_FULL - coverage);
        fg1_reg    <= fg;
        bg1_reg    <= bg;
        mode1_reg  <= mode;

        sum_reg   <= prod_f_reg + prod_b_reg + ROUND_BIAS;
        fg2_reg   <= fg1_reg;
        bg2_reg   <= bg1_reg;
        mode2_reg <= mode1_reg;

        chan_reg <= chan_next;
    end

    assign corr = sum_reg + {8'd0, sum_reg[15:8]};

    always_comb
    begin
        unique case (mode2_reg)
            MODE_BG:  chan_next = bg2_reg;
            MODE_FG:  chan_next = fg2_reg;
            MODE_MIX: chan_next = corr[15:8];
            default:  chan_next = bg2_reg;
        endcase
    end

    assign chan = chan_reg;

endmodule

/* rtl/core/gpbc_addr.sv */
// Three-stage word address computation and surface clip test.
module gpbc_addr
    import gpbc_pkg::*;
(
    input  logic                  clk,
    input  surface_cfg_t          cfg,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    output logic                  write_enable,
    output logic [ADDR_BITS-1:0]  word_address
);

    localparam int PROD_BITS = COORD_BITS + REG_BITS;

    logic [PROD_BITS-1:0]  prod_reg;
    logic [COORD_BITS-1:0] x1_reg;
    logic                  we1_reg;
    logic [ADDR_BITS-1:0]  addr2_reg;
    logic                  we2_reg;
    logic [ADDR_BITS-1:0]  addr3_reg;
    logic                  we3_reg;

    logic                  in_surface;
    logic [PROD_BITS:0]    sum;

    assign in_surface = ({1'b0, pos_x} < REG_BITS'(cfg.surface_width))
                     && ({1'b0, pos_y} < REG_BITS'(cfg.surface_height));
    assign sum        = {1'b0, prod_reg} + (PROD_BITS+1)'(x1_reg);

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_BITS'(pos_y) * PROD_BITS'(cfg.row_stride);
        x1_reg    <= pos_x;
        we1_reg   <= in_surface;

        addr2_reg <= sum[ADDR_BITS-1:0];
        we2_reg   <= we1_reg;

        addr3_reg <= addr2_reg;
        we3_reg   <= we2_reg;
    end

    assign write_enable = we3_reg;
    assign word_address = addr3_reg;

endmodule

/* rtl/core/glyph_pixel_blend_clip_unit.sv */
// Top level: config registers, pixel pipeline valid tracking and result packing.
// The done strobe of an accepted start leaves the last of three valid register stages with its
// result. Throughput: one pixel per clock; busy is never raised. Each channel blend unit has
// three register stages (multiply, add, round/select); the address unit has three (multiply, add, output).
// Reset: rst_n clears valid bits and restores width 640, height 480, stride 640.
// done marks each result for one cycle; the receiver cannot stall.
module glyph_pixel_blend_clip_unit
    import gpbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  item_t                   item,
    output logic                    done,
    output result_t                 result,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data
);

    surface_cfg_t cfg_reg;
    logic [2:0]   valid_reg;
    logic [2:0]   valid_next;
    logic         take;
    mix_mode_t    mode;
    logic         addr_we;
    logic [ADDR_BITS-1:0] addr;
    logic [CHAN_BITS-1:0] chan_r, chan_g, chan_b;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_width  <= RST_SURFACE_WIDTH;
            cfg_reg.surface_height <= RST_SURFACE_HEIGHT;
            cfg_reg.row_stride     <= RST_ROW_STRIDE;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SURFACE_WIDTH)
                cfg_reg.surface_width <= cfg_data;
            if (cfg_index == REG_SURFACE_HEIGHT)
                cfg_reg.surface_height <= cfg_data;
            if (cfg_index == REG_ROW_STRIDE)
                cfg_reg.row_stride <= cfg_data;
        end
    end

    assign valid_next = {valid_reg[1:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_comb
    begin
        priority if (item.kind == KIND_FILL || item.coverage == ALPHA_ZERO)
            mode = MODE_BG;
        else if (item.coverage == ALPHA_FULL)
            mode = MODE_FG;
        else
            mode = MODE_MIX;
    end

    gpbc_mix u_mix_r (
        .clk      (clk),
        .mode     (mode),
        .coverage (item.coverage),
        .fg       (item.fg_color[23:16]),
        .bg       (item.bg_color[23:16]),
        .chan     (chan_r)
    );

    gpbc_mix u_mix_g (
        .clk      (clk),
        .mode     (mode),
        .coverage (item.coverage),
        .fg       (item.fg_color[15:8]),
        .bg       (item.bg_color[15:8]),
        .chan     (chan_g)
    );

    gpbc_mix u_mix_b (
        .clk      (clk),
        .mode     (mode),
        .coverage (item.coverage),
        .fg       (item.fg_color[7:0]),
        .bg       (item.bg_color[7:0]),
        .chan     (chan_b)
    );

    gpbc_addr u_addr (
        .clk          (clk),
        .cfg          (cfg_reg),
        .pos_x        (item.pos_x),
        .pos_y        (item.pos_y),
        .write_enable (addr_we),
        .word_address (addr)
    );

    assign done                = valid_reg[2];
    assign result.write_enable = addr_we;
    assign result.word_address = addr;
    assign result.pixel_value  = {OPAQUE, chan_r, chan_g, chan_b};

endmodule

/* sim/tb.sv */
// Testbench for glyph_pixel_blend_clip_unit: self-checking blend, address and clip tests.
`timescale 1ns / 1ps

module tb;
    import gpbc_pkg::*;

    localparam int LATENCY = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    item_t                   item;
    logic                    done;
    result_t                 result;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0]     cfg_data;

    logic [REG_BITS-1:0] surf_width;
    logic [REG_BITS-1:0] surf_height;
    logic [REG_BITS-1:0] surf_stride;

    result_t pending_writes[$];
    int      error_count;
    int      idle_pct;

    glyph_pixel_blend_clip_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] blend_channel(logic [7:0] f, logic [7:0] b, logic [7:0] a);
        logic [31:0] t;
        t = 32'(f) * 32'(a) + 32'(b) * (32'(ALPHA_FULL) - 32'(a));
        t = t + 32'(ROUND_BIAS);
        t = (t + (t >> 8)) >> 8;
        return t[7:0];
    endfunction

    function automatic result_t predict_write(item_t p);
        result_t     r;
        logic [7:0]  red, grn, blu;
        logic [31:0] addr;
        if (p.kind == KIND_FILL || p.coverage == ALPHA_ZERO)
        begin
            {red, grn, blu} = p.bg_color;
        end
        else if (p.coverage == ALPHA_FULL)
        begin
            {red, grn, blu} = p.fg_color;
        end
        else
        begin
            red = blend_channel(p.fg_color[23:16], p.bg_color[23:16], p.coverage);
            grn = blend_channel(p.fg_color[15:8], p.bg_color[15:8], p.coverage);
            blu = blend_channel(p.fg_color[7:0], p.bg_color[7:0], p.coverage);
        end
        addr = 32'(p.pos_y) * 32'(surf_stride) + 32'(p.pos_x);
        r.write_enable = (32'(p.pos_x) < 32'(surf_width)) && (32'(p.pos_y) < 32'(surf_height));
        r.word_address = addr[ADDR_BITS-1:0];
        r.pixel_value  = {OPAQUE, red, grn, blu};
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] near_edge(logic [REG_BITS-1:0] limit);
        int v;
        v = int'(limit) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic item_t rand_pixel();
        item_t p;
        p.kind  = 1'($urandom_range(0, 1));
        p.pos_x = ($urandom_range(0, 1) == 0) ? COORD_BITS'($urandom_range(0, 4095))
                                              : near_edge(surf_width);
        p.pos_y = ($urandom_range(0, 1) == 0) ? COORD_BITS'($urandom_range(0, 4095))
                                              : near_edge(surf_height);
        case ($urandom_range(0, 7))
            0:       p.coverage = ALPHA_ZERO;
            1:       p.coverage = ALPHA_FULL;
            2:       p.coverage = 8'd1;
            3:       p.coverage = 8'd254;
            default: p.coverage = 8'($urandom_range(0, 255));
        endcase
        p.fg_color = 24'($urandom_range(0, 24'hffffff));
        p.bg_color = 24'($urandom_range(0, 24'hffffff));
        return p;
    endfunction

    function automatic item_t make_pixel(logic kind, int x, int y, int a, int fg, int bg);
        item_t p;
        p.kind     = kind;
        p.pos_x    = x[COORD_BITS-1:0];
        p.pos_y    = y[COORD_BITS-1:0];
        p.coverage = a[7:0];
        p.fg_color = fg[23:0];
        p.bg_color = bg[23:0];
        return p;
    endfunction

    // one transaction; start stays high across back-to-back items
    task automatic send_pixel(item_t p);
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start = 1'b1;
        item  = p;
        do
            @(posedge clk);
        while (busy);
        pending_writes.push_back(predict_write(p));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        start = 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            REG_SURFACE_WIDTH:  surf_width  = val;
            REG_SURFACE_HEIGHT: surf_height = val;
            REG_ROW_STRIDE:     surf_stride = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_surface(int w, int h, int s);
        drain_pipeline();
        write_reg(REG_SURFACE_WIDTH, w[REG_BITS-1:0]);
        write_reg(REG_SURFACE_HEIGHT, h[REG_BITS-1:0]);
        write_reg(REG_ROW_STRIDE, s[REG_BITS-1:0]);
    endtask

    task automatic test_blend_modes();
        idle_pct = 0;
        send_pixel(make_pixel(KIND_FILL, 0, 0, 8'h80, 24'hffffff, 24'h123456));
        send_pixel(make_pixel(KIND_FILL, 1, 0, 8'hff, 24'habcdef, 24'h000000));
        send_pixel(make_pixel(KIND_BLEND, 2, 0, 0, 24'hffffff, 24'h654321));
        send_pixel(make_pixel(KIND_BLEND, 3, 0, 255, 24'hfedcba, 24'h000000));
        send_pixel(make_pixel(KIND_BLEND, 4, 1, 1, 24'hffffff, 24'h000000));
        send_pixel(make_pixel(KIND_BLEND, 5, 1, 254, 24'hffffff, 24'h000000));
        send_pixel(make_pixel(KIND_BLEND, 6, 1, 128, 24'h000000, 24'hffffff));
        send_pixel(make_pixel(KIND_BLEND, 7, 1, 127, 24'hff00ff, 24'h00ff00));
    endtask

    task automatic test_clip_edges();
        send_pixel(make_pixel(KIND_BLEND, 639, 479, 64, 24'h80ff01, 24'h7f00fe));
        send_pixel(make_pixel(KIND_FILL, 640, 0, 0, 24'h0, 24'h112233));
        send_pixel(make_pixel(KIND_FILL, 0, 480, 0, 24'h0, 24'h445566));
        send_pixel(make_pixel(KIND_BLEND, 4095, 4095, 200, 24'hffffff, 24'hffffff));
    endtask

    task automatic test_register_extremes();
        set_surface(0, 480, 640);
        send_pixel(make_pixel(KIND_BLEND, 0, 0, 10, 24'h102030, 24'h405060));
        set_surface(640, 0, 640);
        send_pixel(make_pixel(KIND_BLEND, 0, 0, 250, 24'h102030, 24'h405060));
        set_surface(1, 1, 1);
        send_pixel(make_pixel(KIND_FILL, 0, 0, 0, 24'h0, 24'hffffff));
        send_pixel(make_pixel(KIND_FILL, 1, 1, 0, 24'h0, 24'hffffff));
        // product wraps past 24 bits
        set_surface(8191, 8191, 8191);
        send_pixel(make_pixel(KIND_BLEND, 4095, 4095, 33, 24'haaaaaa, 24'h555555));
        set_surface(4096, 4096, 0);
        send_pixel(make_pixel(KIND_BLEND, 4095, 4095, 99, 24'h0000ff, 24'hff0000));
        // writes to the unused index leave the registers alone
        drain_pipeline();
        write_reg(REG_UNUSED, 13'h1fff);
        send_pixel(make_pixel(KIND_BLEND, 100, 200, 77, 24'h00ff00, 24'h0000ff));
    endtask

    task automatic test_random_traffic();
        int dims[8];
        dims = '{640, 1, 4096, 8191, 1920, 0, 4096, 33};
        for (int ph = 0; ph < 8; ph++)
        begin
            int w;
            int h;
            int s;
            w = ($urandom_range(0, 1) == 0) ? dims[ph] : $urandom_range(1, 4096);
            h = ($urandom_range(0, 1) == 0) ? dims[7 - ph] : $urandom_range(1, 4096);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
            set_surface(w, h, s);
            case (ph % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 67;
                2:       idle_pct = 31;
                default: idle_pct = 67;
            endcase
            repeat (100)
                send_pixel(rand_pixel());
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected transaction: %p", result);
                error_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (result.write_enable !== want.write_enable)
                begin
                    $error("write_enable: expected %0d, got %0d",
                           want.write_enable, result.write_enable);
                    error_count++;
                end
                if (result.word_address !== want.word_address)
                begin
                    $error("word_address: expected %0h, got %0h",
                           want.word_address, result.word_address);
                    error_count++;
                end
                if (result.pixel_value !== want.pixel_value)
                begin
                    $error("pixel_value: expected %0h, got %0h",
                           want.pixel_value, result.pixel_value);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SURFACE_WIDTH;
        cfg_data    = '0;
        surf_width  = RST_SURFACE_WIDTH;
        surf_height = RST_SURFACE_HEIGHT;
        surf_stride = RST_ROW_STRIDE;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_blend_modes();
        test_clip_edges();
        test_register_extremes();
        test_random_traffic();

        drain_pipeline();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/gpbc_pkg.sv
rtl/core/gpbc_mix.sv
rtl/core/gpbc_addr.sv
rtl/core/glyph_pixel_blend_clip_unit.sv
sim/tb.sv
